### hw/rtl/iptx_pkg.sv
`default_nettype none

package iptx_pkg;

	localparam int unsigned GROUP_SLOTS = 8;
	localparam int unsigned MAX_DIGITS  = 4;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [7:0] COLON_CHAR = 8'h3A;

	typedef struct packed {
		logic [7:0] char_in;
		logic       last_char;
	} in_item_t;

	typedef struct packed {
		logic [63:0] addr_high;
		logic [63:0] addr_low;
		logic        malformed;
	} out_item_t;

	// One parsed address, handed from the parser to the expander.
	typedef struct packed {
		logic [GROUP_SLOTS-1:0][15:0] groups;
		logic [3:0]                   count;
		logic [3:0]                   gap_pos;
		logic                         gap;
		logic                         err;
	} job_t;

endpackage

`default_nettype wire

### hw/rtl/iptx_parser.sv
`default_nettype none

module iptx_parser (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire iptx_pkg::in_item_t in_item,
	input  wire logic              q_full,
	output logic                   job_push,
	output iptx_pkg::job_t         job
);
	import iptx_pkg::*;

	logic [15:0] store_q [GROUP_SLOTS];
	logic [3:0]  gd_q;
	logic [3:0]  gp_q;
	logic        gap_q;
	logic [15:0] acc_q;
	logic [2:0]  dc_q;
	logic        prev_q;
	logic        err_q;

	logic        is_hex;
	logic [3:0]  hv;
	logic        at_start;
	logic        accept;

	logic [3:0]  gd1, gdf, gp1;
	logic        gap1, prev1, err1, errf;
	logic [15:0] acc1, wval;
	logic [2:0]  dc1;
	logic        wr;
	logic [2:0]  wr_idx;

	always_comb begin
		is_hex = 1'b1;
		hv     = 4'd0;
		if (in_item.char_in >= 8'h30 && in_item.char_in <= 8'h39) begin
			hv = 4'(in_item.char_in - 8'h30);
		end else if (in_item.char_in >= 8'h61 && in_item.char_in <= 8'h66) begin
			hv = 4'(in_item.char_in - 8'h57);
		end else if (in_item.char_in >= 8'h41 && in_item.char_in <= 8'h46) begin
			hv = 4'(in_item.char_in - 8'h37);
		end else begin
			is_hex = 1'b0;
		end
	end

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign at_start = (gd_q == 4'd0) && !gap_q && (dc_q == 3'd0);
	assign wr_idx   = gd_q[2:0];

	always_comb begin
		acc1  = acc_q;
		dc1   = dc_q;
		gd1   = gd_q;
		gp1   = gp_q;
		gap1  = gap_q;
		prev1 = prev_q;
		err1  = err_q;
		wr    = 1'b0;
		wval  = acc_q;

		priority if (is_hex) begin
			if (prev_q && at_start) err1 = 1'b1;
			if (dc_q >= 3'(MAX_DIGITS)) begin
				err1 = 1'b1;
			end else begin
				acc1 = {acc_q[11:0], hv};
				dc1  = dc_q + 3'd1;
			end
			prev1 = 1'b0;
		end else if (in_item.char_in == COLON_CHAR) begin
			if (prev_q) begin
				if (gap_q) begin
					err1 = 1'b1;
				end else begin
					gap1 = 1'b1;
					gp1  = gd_q;
				end
			end else if (dc_q != 3'd0) begin
				if (gd_q >= 4'(GROUP_SLOTS)) begin
					err1 = 1'b1;
				end else begin
					wr  = 1'b1;
					gd1 = gd_q + 4'd1;
				end
				acc1 = 16'd0;
				dc1  = 3'd0;
			end
			prev1 = 1'b1;
		end else begin
			err1 = 1'b1;
		end

		// End of text: close the open group and check the group count.
		errf = err1;
		gdf  = gd1;
		if (dc1 != 3'd0) begin
			if (gd1 >= 4'(GROUP_SLOTS)) begin
				errf = 1'b1;
			end else if (in_item.last_char) begin
				wr   = 1'b1;
				wval = acc1;
				gdf  = gd1 + 4'd1;
			end
		end else if (prev1 && !(gap1 && gp1 == gd1)) begin
			errf = 1'b1;
		end
		if (gap1) begin
			if (gdf >= 4'(GROUP_SLOTS)) errf = 1'b1;
		end else begin
			if (gdf != 4'(GROUP_SLOTS)) errf = 1'b1;
		end
	end

	always_comb begin
		for (int i = 0; i < GROUP_SLOTS; i++) begin
			job.groups[i] = (wr && wr_idx == 3'(i)) ? wval : store_q[i];
		end
		job.count   = gdf;
		job.gap_pos = gp1;
		job.gap     = gap1;
		job.err     = errf;
	end

	assign job_push = accept && in_item.last_char;

	always_ff @(posedge clk) begin
		if (accept && wr) store_q[wr_idx] <= wval;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gd_q   <= '0;
			gp_q   <= '0;
			gap_q  <= 1'b0;
			acc_q  <= '0;
			dc_q   <= '0;
			prev_q <= 1'b0;
			err_q  <= 1'b0;
		end else if (accept) begin
			if (in_item.last_char) begin
				gd_q   <= '0;
				gp_q   <= '0;
				gap_q  <= 1'b0;
				acc_q  <= '0;
				dc_q   <= '0;
				prev_q <= 1'b0;
				err_q  <= 1'b0;
			end else begin
				gd_q   <= gd1;
				gp_q   <= gp1;
				gap_q  <= gap1;
				acc_q  <= acc1;
				dc_q   <= dc1;
				prev_q <= prev1;
				err_q  <= err1;
			end
		end
	end

	a_digits_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		dc_q <= 3'(MAX_DIGITS))
		else $error("digit count past group width");

	a_groups_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		gd_q <= 4'(GROUP_SLOTS))
		else $error("group count past slot count");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |=> (gd_q == 4'd0 && dc_q == 3'd0 && !gap_q && !err_q))
		else $error("parser state not cleared after address end");

endmodule

`default_nettype wire

### hw/rtl/iptx_queue.sv
`default_nettype none

module iptx_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire iptx_pkg::job_t push_job,
	output logic               full,
	input  wire logic          pop,
	output logic               head_valid,
	output iptx_pkg::job_t     head_job
);
	import iptx_pkg::*;

	job_t       ent_q [QUEUE_DEPTH];
	logic [1:0] cnt_q;
	logic       widx;

	assign full       = (cnt_q == 2'(QUEUE_DEPTH));
	assign head_valid = (cnt_q != 2'd0);
	assign head_job   = ent_q[0];
	assign widx       = pop ? 1'b0 : cnt_q[0];

	// Shift on pop, then place the incoming job behind what remains.
	always_ff @(posedge clk) begin
		if (push && !widx) begin
			ent_q[0] <= push_job;
		end else if (pop) begin
			ent_q[0] <= ent_q[1];
		end
		if (push && widx) ent_q[1] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'(QUEUE_DEPTH))
		else $error("queue count overflow");

	a_pop_only_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> (cnt_q == $past(cnt_q) - 2'd1))
		else $error("queue count did not drop on pop");

endmodule

`default_nettype wire

### hw/rtl/iptx_expander.sv
`default_nettype none

module iptx_expander (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           head_valid,
	input  wire iptx_pkg::job_t head_job,
	output logic                pop,
	output logic                out_valid,
	input  wire logic           out_ready,
	output iptx_pkg::out_item_t out_item
);
	import iptx_pkg::*;

	logic [GROUP_SLOTS-1:0][15:0] slots;
	logic [3:0]                   shift;
	logic [3:0]                   src;
	logic                         out_valid_q;
	out_item_t                    out_item_q;

	assign shift = 4'(GROUP_SLOTS) - head_job.count;

	// Groups before the gap keep their slot; those after it move to the tail.
	always_comb begin
		for (int j = 0; j < GROUP_SLOTS; j++) begin
			slots[j] = 16'd0;
			src      = 4'(j);
			if (head_job.gap && 4'(j) >= head_job.gap_pos) begin
				src = 4'(j) - shift;
				if (5'(j) >= 5'(head_job.gap_pos) + 5'(shift)) slots[j] = head_job.groups[src[2:0]];
			end else if (4'(j) < head_job.count) begin
				slots[j] = head_job.groups[src[2:0]];
			end
			if (head_job.err) slots[j] = 16'd0;
		end
	end

	assign pop = head_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk) begin
		if (pop) begin
			out_item_q.addr_high <= {slots[0], slots[1], slots[2], slots[3]};
			out_item_q.addr_low  <= {slots[4], slots[5], slots[6], slots[7]};
			out_item_q.malformed <= head_job.err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

`default_nettype wire

### hw/rtl/ipv6_text_address_expander_unit.sv
// An address is written into the job queue when its last character is taken; the expander then registers the beat.
// One character per cycle while the job queue is not full; the parser updates its registers on each character.
// A two-entry job queue lets the parser keep taking characters while a result waits.
// The expander places groups around the gap and loads the output register when it pops a job.
// Reset (arst_n low, asynchronous) clears parser state, queue count and output valid.
`default_nettype none

module ipv6_text_address_expander_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire iptx_pkg::in_item_t  in_item,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output iptx_pkg::out_item_t     out_item
);
	import iptx_pkg::*;

	// Parser to queue: one job per completed address text.
	logic job_push;
	job_t job;
	logic q_full;

	// Queue to expander.
	logic head_valid;
	job_t head_job;
	logic pop;

	// Parse characters, track groups and the double colon, flag malformed text.
	iptx_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.q_full   (q_full),
		.job_push (job_push),
		.job      (job)
	);

	// Hold finished addresses so a stalled output does not stall the parser at once.
	iptx_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (job_push),
		.push_job   (job),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	// Expand the gap with zero groups and register the 128-bit result beat.
	iptx_expander u_expander (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_item   (out_item)
	);

endmodule

`default_nettype wire
